// ===== src/its_pkg.sv =====
// Shared types, sizes and the key compare for the index tracking sort.
// Used by the cell, the chain and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package its_pkg;

    localparam int CAPACITY  = 32;
    localparam int KEY_WIDTH = 32;
    localparam int TAG_WIDTH = 16;

    typedef logic signed [KEY_WIDTH-1:0] t_key;
    typedef logic        [TAG_WIDTH-1:0] t_tag;

    // Per-cycle command shared by every cell of a chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    // True when a new key must stay behind a held key. Equal keys stay behind,
    // which keeps arrival order among ties.
    function automatic logic stays_after(input t_key new_key, input t_key held_key,
                                         input logic desc);
        logic result;
        if (desc) begin
            result = (held_key >= new_key);
        end else begin
            result = (held_key <= new_key);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== src/its_cell.sv =====
// One cell of the insertion chain: holds one key and tag with a valid flag.
// Depends on its_pkg.
`timescale 1ns / 1ps
`default_nettype none

module its_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  its_pkg::t_cell_ctrl i_ctrl,
    input  wire                 i_desc,
    input  its_pkg::t_key       i_new_key,
    input  its_pkg::t_tag       i_new_tag,
    input  wire                 i_prev_valid,
    input  wire                 i_prev_before,
    input  its_pkg::t_key       i_prev_key,
    input  its_pkg::t_tag       i_prev_tag,
    input  wire                 i_next_valid,
    input  its_pkg::t_key       i_next_key,
    input  its_pkg::t_tag       i_next_tag,
    output logic                o_valid,
    output logic                o_before,
    output its_pkg::t_key       o_key,
    output its_pkg::t_tag       o_tag
);
    import its_pkg::*;

    logic r_valid;
    logic n_valid;
    t_key r_key;
    t_key n_key;
    t_tag r_tag;
    t_tag n_tag;

    // The new word belongs at or ahead of this cell.
    assign o_before = !r_valid || !stays_after(i_new_key, r_key, i_desc);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
            n_tag   = i_next_tag;
        end else if (i_ctrl.insert && o_before) begin
            if (i_prev_before) begin
                // Insertion point is further up: take the neighbor's entry.
                n_valid = i_prev_valid;
                n_key   = i_prev_key;
                n_tag   = i_prev_tag;
            end else begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_tag   = i_new_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

// ===== src/its_chain.sv =====
// A row of CAPACITY insertion cells kept in sorted order, head at cell 0.
// Depends on its_pkg and its_cell.
`timescale 1ns / 1ps
`default_nettype none

module its_chain (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  its_pkg::t_cell_ctrl i_ctrl,
    input  wire                 i_desc,
    input  its_pkg::t_key       i_new_key,
    input  its_pkg::t_tag       i_new_tag,
    output its_pkg::t_key       o_head_key,
    output its_pkg::t_tag       o_head_tag,
    output logic                o_second_valid,
    output logic                o_full
);
    import its_pkg::*;

    logic w_valid  [CAPACITY];
    logic w_before [CAPACITY];
    t_key w_key    [CAPACITY];
    t_tag w_tag    [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic w_pv;
            logic w_pb;
            t_key w_pk;
            t_tag w_pt;
            logic w_nv;
            t_key w_nk;
            t_tag w_nt;

            if (g == 0) begin : g_head
                assign w_pv = 1'b0;
                assign w_pb = 1'b0;
                assign w_pk = '0;
                assign w_pt = '0;
            end else begin : g_body
                assign w_pv = w_valid[g-1];
                assign w_pb = w_before[g-1];
                assign w_pk = w_key[g-1];
                assign w_pt = w_tag[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_nv = 1'b0;
                assign w_nk = '0;
                assign w_nt = '0;
            end else begin : g_mid
                assign w_nv = w_valid[g+1];
                assign w_nk = w_key[g+1];
                assign w_nt = w_tag[g+1];
            end

            its_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_desc       (i_desc),
                .i_new_key    (i_new_key),
                .i_new_tag    (i_new_tag),
                .i_prev_valid (w_pv),
                .i_prev_before(w_pb),
                .i_prev_key   (w_pk),
                .i_prev_tag   (w_pt),
                .i_next_valid (w_nv),
                .i_next_key   (w_nk),
                .i_next_tag   (w_nt),
                .o_valid      (w_valid[g]),
                .o_before     (w_before[g]),
                .o_key        (w_key[g]),
                .o_tag        (w_tag[g])
            );
        end
    endgenerate

    assign o_head_key     = w_key[0];
    assign o_head_tag     = w_tag[0];
    assign o_second_valid = w_valid[1];
    assign o_full         = w_valid[CAPACITY-1];

endmodule

`default_nettype wire

// ===== src/index_tracking_sort.sv =====
// Stable argsort: one word per cycle, when the input is not stalled, enters two insertion
// chains (ascending and descending); the run ends on last_in. The first result is offered
// in the cycle after the last word is accepted, then one result per cycle unless i_out_stall
// holds it, n results for n held words. Input is stalled while results drain.
// Synchronous active-low reset empties the chains and clears the mode register.
// Words arriving while CAPACITY words are held are dropped.
`timescale 1ns / 1ps
`default_nettype none

module index_tracking_sort (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_wr_en,
    input  wire                i_cfg_wr_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  its_pkg::t_key      i_key,
    input  its_pkg::t_tag      i_tag,
    input  wire                i_last_in,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output its_pkg::t_key      o_sorted_key,
    output its_pkg::t_tag      o_sorted_tag,
    output logic               o_last_out
);
    import its_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic       r_descending;
    logic       r_out_desc;
    logic       n_out_desc;
    t_cell_ctrl w_ctrl;
    logic       w_in_acc;
    logic       w_out_acc;
    t_key       w_asc_key;
    t_tag       w_asc_tag;
    logic       w_asc_second;
    logic       w_asc_full;
    t_key       w_dsc_key;
    t_tag       w_dsc_tag;
    logic       w_dsc_second;
    logic       w_dsc_full;

    assign o_in_stall  = (r_state == ST_DRAIN);
    assign o_out_valid = (r_state == ST_DRAIN);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = o_out_valid && !i_out_stall;

    // Both chains fill together, so either one tells when the row is full.
    assign w_ctrl.insert = w_in_acc && !(w_asc_full || w_dsc_full);
    assign w_ctrl.shift  = w_out_acc;

    its_chain u_asc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_desc        (1'b0),
        .i_new_key     (i_key),
        .i_new_tag     (i_tag),
        .o_head_key    (w_asc_key),
        .o_head_tag    (w_asc_tag),
        .o_second_valid(w_asc_second),
        .o_full        (w_asc_full)
    );

    its_chain u_dsc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_desc        (1'b1),
        .i_new_key     (i_key),
        .i_new_tag     (i_tag),
        .o_head_key    (w_dsc_key),
        .o_head_tag    (w_dsc_tag),
        .o_second_valid(w_dsc_second),
        .o_full        (w_dsc_full)
    );

    always_comb begin
        n_state    = r_state;
        n_out_desc = r_out_desc;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_last_in) begin
                    n_state    = ST_DRAIN;
                    n_out_desc = r_descending;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && o_last_out) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_descending <= 1'b0;
            r_out_desc   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_desc <= n_out_desc;
            if (i_cfg_wr_en) begin
                r_descending <= i_cfg_wr_data;
            end
        end
    end

    always_comb begin
        if (r_out_desc) begin
            o_sorted_key = w_dsc_key;
            o_sorted_tag = w_dsc_tag;
            o_last_out   = !w_dsc_second;
        end else begin
            o_sorted_key = w_asc_key;
            o_sorted_tag = w_asc_tag;
            o_last_out   = !w_asc_second;
        end
    end

endmodule

`default_nettype wire

// ===== src/its_checker.sv =====
// Port-level checks for index_tracking_sort, attached by the bind below.
// Depends on its_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module its_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_cfg_wr_en,
    input wire           i_cfg_wr_data,
    input wire           i_in_valid,
    input wire           o_in_stall,
    input its_pkg::t_key i_key,
    input its_pkg::t_tag i_tag,
    input wire           i_last_in,
    input wire           o_out_valid,
    input wire           i_out_stall,
    input its_pkg::t_key o_sorted_key,
    input its_pkg::t_tag o_sorted_tag,
    input wire           o_last_out
);

    // After reset no word is offered.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The input side is held off while results drain.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while results pending");

    // The end of a run starts the result run on the next cycle.
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_in) |=> (o_out_valid && !i_cfg_wr_en) ||
        o_out_valid)
        else $error("no result after the last input word");

    // The result run does not end before the marked word.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_out) |=> o_out_valid)
        else $error("result run ended before last_out");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sorted_key) &&
        $stable(o_sorted_tag) && $stable(o_last_out)))
        else $error("stalled result word changed");

endmodule

bind index_tracking_sort its_checker u_its_checker (.*);

`default_nettype wire
